// ===== src/md5hc_pkg.sv =====
package md5hc_pkg;

    // iteration counter width
    localparam int COUNT_BITS = 16;
    localparam int FOLD_BYTES = 8;

    typedef logic [COUNT_BITS-1:0] t_count;

    // md5 initial chaining words
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // fixed message words of the single padded block
    localparam logic [31:0] MSG_PAD = 32'h00000080;
    localparam logic [31:0] MSG_LEN = 32'(FOLD_BYTES * 8);

    // last round of one compression
    localparam logic [5:0] LAST_ROUND = 6'd63;

    // round function groups
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic run_round;
        logic fold;
        logic out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic last_round;
    } t_dp_sts;

    // additive round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // left rotate amount, by group and position in group of four
    function automatic logic [4:0] rot_amt(input logic [5:0] idx);
        logic [4:0] s;
        unique case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used by a round
    function automatic logic [3:0] msg_sel(input logic [5:0] idx);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = idx[3:0];
        unique case (idx[5:4])
            GRP_F:   g = i4;
            GRP_G:   g = 4'(i4 * 4'd5 + 4'd1);
            GRP_H:   g = 4'(i4 * 4'd3 + 4'd5);
            GRP_I:   g = 4'(i4 * 4'd7);
            default: g = i4;
        endcase
        return g;
    endfunction

    // 32-bit left rotate
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    // byte reversal of a word
    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== src/md5hc_dpath.sv =====
module md5hc_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [63:0]           i_start_value,
    input  logic [15:0]           i_iteration_count,
    input  md5hc_pkg::t_dp_cmd    i_cmd,
    output md5hc_pkg::t_dp_sts    o_sts,
    output logic [63:0]           o_chain_value
);

    // message word slots that are not zero
    localparam logic [3:0] MSG_IDX_HI  = 4'd0;
    localparam logic [3:0] MSG_IDX_LO  = 4'd1;
    localparam logic [3:0] MSG_IDX_PAD = 4'd2;
    localparam logic [3:0] MSG_IDX_LEN = 4'd14;

    logic [63:0]          r_value;
    md5hc_pkg::t_count    r_count;
    logic [5:0]           r_round;
    logic [31:0]          r_a, r_b, r_c, r_d;
    logic [63:0]          r_out;

    logic [31:0]          f_val;
    logic [31:0]          m_val;
    logic [31:0]          sum;
    logic [31:0]          n_b;
    logic [31:0]          fold_lo, fold_hi;
    logic [63:0]          n_value;

    // round function
    always_comb begin
        unique case (r_round[5:4])
            md5hc_pkg::GRP_F: f_val = (r_b & r_c) | (~r_b & r_d);
            md5hc_pkg::GRP_G: f_val = (r_d & r_b) | (~r_d & r_c);
            md5hc_pkg::GRP_H: f_val = r_b ^ r_c ^ r_d;
            md5hc_pkg::GRP_I: f_val = r_c ^ (r_b | ~r_d);
            default:          f_val = r_b ^ r_c ^ r_d;
        endcase
    end

    // message word for this round, bytes taken little-endian from the value
    always_comb begin
        unique case (md5hc_pkg::msg_sel(r_round))
            MSG_IDX_HI:  m_val = md5hc_pkg::bswap32(r_value[63:32]);
            MSG_IDX_LO:  m_val = md5hc_pkg::bswap32(r_value[31:0]);
            MSG_IDX_PAD: m_val = md5hc_pkg::MSG_PAD;
            MSG_IDX_LEN: m_val = md5hc_pkg::MSG_LEN;
            default:     m_val = 32'h0;
        endcase
    end

    // one md5 step
    assign sum = r_a + f_val + md5hc_pkg::round_k(r_round) + m_val;
    assign n_b = r_b + md5hc_pkg::rotl32(sum, md5hc_pkg::rot_amt(r_round));

    // digest halves folded together, first digest byte most significant
    assign fold_lo = (md5hc_pkg::IV_A + r_a) ^ (md5hc_pkg::IV_C + r_c);
    assign fold_hi = (md5hc_pkg::IV_B + r_b) ^ (md5hc_pkg::IV_D + r_d);
    assign n_value = {md5hc_pkg::bswap32(fold_lo), md5hc_pkg::bswap32(fold_hi)};

    // iteration and round counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_round <= '0;
        end else if (i_cmd.load) begin
            r_count <= md5hc_pkg::t_count'(i_iteration_count);
            r_round <= '0;
        end else if (i_cmd.run_round) begin
            r_round <= r_round + 6'd1;
        end else if (i_cmd.fold) begin
            r_count <= r_count - md5hc_pkg::t_count'(1);
            r_round <= '0;
        end
    end

    // chain value and working words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_start_value;
            r_a     <= md5hc_pkg::IV_A;
            r_b     <= md5hc_pkg::IV_B;
            r_c     <= md5hc_pkg::IV_C;
            r_d     <= md5hc_pkg::IV_D;
        end else if (i_cmd.run_round) begin
            r_a <= r_d;
            r_b <= n_b;
            r_c <= r_b;
            r_d <= r_c;
        end else if (i_cmd.fold) begin
            r_value <= n_value;
            r_a     <= md5hc_pkg::IV_A;
            r_b     <= md5hc_pkg::IV_B;
            r_c     <= md5hc_pkg::IV_C;
            r_d     <= md5hc_pkg::IV_D;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_value;
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_one  = (r_count == md5hc_pkg::t_count'(1));
    assign o_sts.last_round = (r_round == md5hc_pkg::LAST_ROUND);
    assign o_chain_value    = r_out;

endmodule

// ===== src/md5hc_ctrl.sv =====
module md5hc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output md5hc_pkg::t_dp_cmd    o_cmd,
    input  md5hc_pkg::t_dp_sts    i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_FOLD,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.count_zero ? S_DONE : S_RUN;
            end
            S_RUN: begin
                o_cmd.run_round = 1'b1;
                if (i_sts.last_round) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = i_sts.count_one ? S_DONE : S_RUN;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the result is taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/md5_fold_hash_chain_core.sv =====
// md5 hash chain core: repeated md5-and-fold of a 64-bit chain value
//
// input channel: i_in_valid / o_in_stall carry a request of i_start_value and
// i_iteration_count. a request is taken when valid is high and stall is low.
// output channel: o_out_valid / i_out_stall carry o_chain_value.
// each iteration runs the 64 md5 rounds, one round per cycle through a single
// round unit, then folds the digest into the next chain value. a count of
// zero runs no iteration and returns the start value as the result.
// one request is worked on at a time; the next one is accepted as soon as
// the previous result sits in the output register, even if not yet taken.
// a stalled result holds in the output register; a finished result waits
// in the core until the output register is free, and no new request is
// accepted meanwhile.
// reset (synchronous, active low) returns the core to idle and drops
// o_out_valid; no request is in flight afterwards.
module md5_fold_hash_chain_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_start_value,
    input  logic [15:0] i_iteration_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_chain_value
);

    md5hc_pkg::t_dp_cmd cmd;
    md5hc_pkg::t_dp_sts sts;

    // sequencer
    md5hc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // round unit, fold and output register
    md5hc_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start_value     (i_start_value),
        .i_iteration_count (i_iteration_count),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_chain_value     (o_chain_value)
    );

endmodule

// ===== src/md5hc_chk.sv =====
module md5hc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_chain_value
);

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_chain_value))
        else $error("result changed while stalled");

    // a taken request makes the core busy at once
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("core not busy after taking a request");

    // a result needs at least the check and hand-off cycles
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("result shown too early");

    // reset leaves the core idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("core not idle after reset");

endmodule

bind md5_fold_hash_chain_core md5hc_chk u_chk (.*);
